[hw/rtl/hcbp_pkg.sv]
// shared constants, opcodes and command types of the huffman code bit packer
`timescale 1ns / 1ps

package hcbp_pkg;

    // table and code geometry
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int SYMBOL_W     = 8;
    localparam int OP_W         = 2;
    localparam int INDEX_W      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int ACC_W        = CODE_W + BYTE_W;

    // command queue between lookup and packer
    localparam int FIFO_DEPTH   = 2;
    localparam int PTR_W        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // one packer command: a looked-up code or a flush
    typedef struct packed {
        logic              is_flush;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } hcbp_cmd_t;

    // queue write side
    typedef struct packed {
        logic      valid;
        hcbp_cmd_t cmd;
    } hcbp_push_t;

    // queue read side
    typedef struct packed {
        logic      valid;
        hcbp_cmd_t cmd;
    } hcbp_pop_t;

endpackage

[hw/rtl/hcbp_in_if.sv]
// input request channel: opcode, symbol and code fields
`timescale 1ns / 1ps

interface hcbp_in_if;
    import hcbp_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [SYMBOL_W-1:0] symbol;
    logic [CODE_W-1:0]   code_value;
    logic [LEN_W-1:0]    code_length;

    modport source (output valid, output opcode, output symbol, output code_value,
                    output code_length, input ready);
    modport sink (input valid, input opcode, input symbol, input code_value,
                  input code_length, output ready);
endinterface

[hw/rtl/hcbp_out_if.sv]
// output request channel: packed byte and end-of-run mark
`timescale 1ns / 1ps

interface hcbp_out_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[hw/rtl/hcbp_front.sv]
// front end: decodes requests, owns the code table, issues packer commands
`timescale 1ns / 1ps

module hcbp_front
    import hcbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hcbp_in_if.sink    items,
    input  logic       fifo_full,
    output hcbp_push_t push
);

    logic [LEN_W+CODE_W-1:0] table_mem [SYMBOL_COUNT];
    logic [LEN_W+CODE_W-1:0] rd_data_reg;
    logic                    is_flush_reg;
    logic                    stage_valid_reg;
    logic                    stage_valid_next;

    logic                    accept;
    logic                    push_ok;
    logic                    in_range;
    logic [INDEX_W-1:0]      index;
    logic [LEN_W-1:0]        len_capped;
    logic                    do_load;
    logic                    do_issue;
    op_t                     op;

    assign op         = op_t'(items.opcode);
    assign index      = items.symbol[INDEX_W-1:0];
    assign in_range   = ({1'b0, items.symbol} < (SYMBOL_W+1)'(SYMBOL_COUNT));
    assign len_capped = (items.code_length > LEN_W'(LEN_CAP)) ?
                        LEN_W'(LEN_CAP) : items.code_length;

    // stage frees when its command enters the queue
    assign push_ok     = stage_valid_reg && !fifo_full;
    assign items.ready = !stage_valid_reg || !fifo_full;
    assign accept      = items.valid && items.ready;

    // opcode decode
    always_comb
    begin
        do_load  = 1'b0;
        do_issue = 1'b0;
        case (op)
            OP_LOAD:
            begin
                do_load = in_range;
            end
            OP_ENCODE:
            begin
                do_issue = in_range;
            end
            OP_FLUSH:
            begin
                do_issue = 1'b1;
            end
            default:
            begin
                do_load  = 1'b0;
                do_issue = 1'b0;
            end
        endcase
    end

    // code table, write on load, registered read on every request
    always_ff @(posedge clk)
    begin
        if (accept && do_load)
        begin
            table_mem[index] <= {len_capped, items.code_value};
        end
        if (accept)
        begin
            rd_data_reg  <= table_mem[index];
            is_flush_reg <= (op == OP_FLUSH);
        end
    end

    // issue stage occupancy
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = do_issue;
        end
        else if (push_ok)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    assign push.valid        = stage_valid_reg;
    assign push.cmd.is_flush = is_flush_reg;
    assign push.cmd.len      = rd_data_reg[LEN_W+CODE_W-1:CODE_W];
    assign push.cmd.bits     = rd_data_reg[CODE_W-1:0];

    // a blocked command stays in the stage
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && fifo_full) |=> stage_valid_reg)
        else $error("issue stage dropped a blocked command");

endmodule

[hw/rtl/hcbp_fifo.sv]
// short command queue between front end and packer
`timescale 1ns / 1ps

module hcbp_fifo
    import hcbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hcbp_push_t push,
    output logic       full,
    output hcbp_pop_t  pop,
    input  logic       pop_ready
);

    hcbp_cmd_t          entry_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == COUNT_W'(FIFO_DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop_ready && (count_reg != '0);

    assign pop.valid = (count_reg != '0);
    assign pop.cmd   = entry_mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push.cmd;
        end
    end

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // fill count stays within depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(FIFO_DEPTH))
        else $error("command queue over capacity");

endmodule

[hw/rtl/hcbp_back.sv]
// packer: appends code bits msb first and emits bytes through an output register
`timescale 1ns / 1ps

module hcbp_back
    import hcbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hcbp_pop_t  pop,
    output logic       pop_ready,
    hcbp_out_if.source packed_out
);

    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [LEN_W-1:0]      cnt_reg, cnt_next;
    logic                  flush_reg, flush_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;

    logic                  have_byte;
    logic                  slot_free;
    logic                  emit;
    logic                  take;
    logic [2*CODE_W-1:0]   code_wide;
    logic [CODE_W-1:0]     code_aligned;
    logic [ACC_W-1:0]      code_placed;

    assign have_byte = (cnt_reg >= LEN_W'(BYTE_W));
    assign slot_free = !out_valid_reg || packed_out.ready;
    assign emit      = slot_free && (have_byte || flush_reg);
    assign pop_ready = !have_byte && !flush_reg;
    assign take      = pop_ready && pop.valid;

    // left-align the code, then place it right after the pending bits
    assign code_wide    = {pop.cmd.bits, CODE_W'(0)} >> pop.cmd.len;
    assign code_aligned = code_wide[CODE_W-1:0];
    assign code_placed  = {code_aligned, BYTE_W'(0)} >> cnt_reg;

    // accumulator and byte emission
    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        flush_next     = flush_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = packed_out.ready ? 1'b0 : out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = acc_reg[ACC_W-1:ACC_W-BYTE_W];
            if (have_byte)
            begin
                out_last_next = (cnt_reg < LEN_W'(2 * BYTE_W));
                acc_next      = {acc_reg[ACC_W-BYTE_W-1:0], BYTE_W'(0)};
                cnt_next      = cnt_reg - LEN_W'(BYTE_W);
            end
            else
            begin
                out_last_next = 1'b1;
                acc_next      = '0;
                cnt_next      = '0;
                flush_next    = 1'b0;
            end
        end
        if (take)
        begin
            if (pop.cmd.is_flush)
            begin
                flush_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg | code_placed;
                cnt_next = cnt_reg + pop.cmd.len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign packed_out.valid       = out_valid_reg;
    assign packed_out.out_byte    = out_byte_reg;
    assign packed_out.last_of_run = out_last_reg;

    // accumulator never holds more than one code plus a partial byte
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LEN_W'(ACC_W - 1))
        else $error("bit accumulator overflow");

    // a pending flush only waits with less than a full byte held
    a_flush_partial: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (cnt_reg < LEN_W'(BYTE_W)))
        else $error("flush pending with full bytes held");

    // a flush byte leaves the accumulator empty
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !have_byte) |=> (cnt_reg == '0) && !flush_reg)
        else $error("flush did not clear pending bits");

endmodule

[hw/rtl/huffman_code_bit_packer.sv]
// top level of the huffman code bit packer
//
//   channel   | dir | payload                                        | request
//   ----------+-----+------------------------------------------------+-----------------
//   items     | in  | opcode, symbol, code_value, code_length        | load/encode/flush
//   packed_out| out | out_byte, last_of_run                          | one packed byte
//
// the code table read is registered, so a command reaches the queue via the issue stage.
// the packer takes a command only once the full bytes of the last one are out (up to
// four per encode), so bursts are bounded by the single byte-per-cycle output register
// while the sink is ready. reset clears the pending bits and all handshake state; the
// code table is not cleared. either side may stall on its own behind the queue.
`timescale 1ns / 1ps

module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hcbp_in_if.sink    items,
    hcbp_out_if.source packed_out
);

    hcbp_push_t push;
    hcbp_pop_t  pop;
    logic       fifo_full;
    logic       pop_ready;

    // lookup and decode
    hcbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .fifo_full (fifo_full),
        .push      (push)
    );

    // command queue
    hcbp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (fifo_full),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    // bit packer
    hcbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_ready  (pop_ready),
        .packed_out (packed_out)
    );

endmodule

[tb/huffman_code_bit_packer_test.sv]
// self-checking testbench of the huffman code bit packer
`timescale 1ns / 1ps

module huffman_code_bit_packer_test;
    import hcbp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 60;
    localparam int MAX_HOLD     = 19;
    localparam int DRAIN_CYCLES = 16;

    // one expected packed byte
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } packed_byte_t;

    // mirror of the code table and pending bits, plus the bytes still owed
    class byte_scoreboard;
        logic [CODE_W-1:0] code_bits [SYMBOL_COUNT];
        logic [LEN_W-1:0]  code_len [SYMBOL_COUNT];
        logic [BYTE_W-1:0] acc_byte;
        int                acc_count;
        packed_byte_t      bytes_due [$];
        int                mismatches;

        function new();
            acc_byte   = '0;
            acc_count  = 0;
            mismatches = 0;
        endfunction

        // predict the bytes that an accepted request produces
        function void note_request(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
                                   input logic [CODE_W-1:0] val, input logic [LEN_W-1:0] len);
            int           produced;
            packed_byte_t one;
            produced = 0;
            case (op)
                OP_LOAD:
                begin
                    if (int'(sym) < SYMBOL_COUNT)
                    begin
                        code_bits[sym] = val;
                        code_len[sym]  = (int'(len) > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
                    end
                end
                OP_ENCODE:
                begin
                    if (int'(sym) < SYMBOL_COUNT)
                    begin
                        // earliest code bit first, filling each byte from bit 7 down
                        for (int i = int'(code_len[sym]); i > 0; i--)
                        begin
                            acc_byte[7 - acc_count] = code_bits[sym][i - 1];
                            acc_count++;
                            if (acc_count == 8)
                            begin
                                one.value = acc_byte;
                                one.last  = 1'b0;
                                bytes_due.insert(bytes_due.size(), one);
                                produced++;
                                acc_byte  = '0;
                                acc_count = 0;
                            end
                        end
                        if (produced > 0)
                            bytes_due[bytes_due.size() - 1].last = 1'b1;
                    end
                end
                OP_FLUSH:
                begin
                    one.value = acc_byte;
                    one.last  = 1'b1;
                    bytes_due.insert(bytes_due.size(), one);
                    acc_byte  = '0;
                    acc_count = 0;
                end
                default:
                begin
                    // unused opcode leaves everything alone
                end
            endcase
        endfunction

        // compare an accepted byte with the oldest one owed
        function void check_byte(input logic [BYTE_W-1:0] value, input logic last);
            packed_byte_t want;
            if (bytes_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: byte with none expected, expected none, actual %h last %b",
                         $time, value, last);
            end
            else
            begin
                want = bytes_due.pop_front();
                if (value !== want.value)
                begin
                    mismatches++;
                    $display("%0t: out_byte expected %h actual %h", $time, want.value, value);
                end
                if (last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    hcbp_in_if  items_if ();
    hcbp_out_if bytes_if ();

    huffman_code_bit_packer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items_if),
        .packed_out (bytes_if)
    );

    byte_scoreboard            book;
    bit                        calm;
    bit                        sym_loaded [SYMBOL_COUNT];
    logic [SYMBOL_W-1:0]       loaded_syms [$];

    always #6 clk = ~clk;

    // lengths mostly short, some long, a few beyond the cap
    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 13)
            return LEN_W'($urandom_range(1, 12));
        if (r < 18)
            return LEN_W'($urandom_range(13, 32));
        return LEN_W'($urandom_range(33, 63));
    endfunction

    // offer one request, with an occasional idle burst ahead of it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
                             input logic [CODE_W-1:0] val, input logic [LEN_W-1:0] len);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            items_if.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_HOLD)) @(posedge clk);
        end
        items_if.valid       <= 1'b1;
        items_if.opcode      <= op;
        items_if.symbol      <= sym;
        items_if.code_value  <= val;
        items_if.code_length <= len;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        book.note_request(op, sym, val, len);
        if (op == OP_LOAD && !sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.insert(loaded_syms.size(), sym);
        end
    endtask

    // main sequence
    initial
    begin
        int unsigned pick;
        book = new();
        calm = 1'b0;
        rst_n                <= 1'b0;
        items_if.valid       <= 1'b0;
        items_if.opcode      <= OP_LOAD;
        items_if.symbol      <= '0;
        items_if.code_value  <= '0;
        items_if.code_length <= '0;
        bytes_if.ready       <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty flush, empty and full-width codes, saturation, overwrite
        send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(OP_LOAD, 8'd0, 32'h1234_5678, 6'd0);
        send_item(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
        send_item(OP_LOAD, 8'd128, 32'h0000_0055, 6'd7);
        send_item(OP_LOAD, 8'd2, 32'hA5A5_5AA5, 6'd63);
        send_item(OP_LOAD, 8'd3, 32'h8000_0001, 6'd33);
        send_item(OP_LOAD, 8'd1, 32'h0000_0001, 6'd1);
        send_item(OP_ENCODE, 8'd0, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd128, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd2, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd3, 32'h0, 6'd0);
        send_item(OP_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_ENCODE, 8'd1, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_LOAD, 8'd1, 32'h0, 6'd8);
        send_item(OP_ENCODE, 8'd1, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd0, 32'h0, 6'd0);
        send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);

        // fill part of the table with random codes
        repeat (20)
            send_item(OP_LOAD, SYMBOL_W'($urandom_range(0, 255)), $urandom(), pick_length());

        // random mix, mostly encodes of loaded symbols
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 14)
                send_item(OP_LOAD, SYMBOL_W'($urandom_range(0, 255)), $urandom(),
                          pick_length());
            else if (pick < 80)
                send_item(OP_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                          $urandom(), LEN_W'($urandom()));
            else if (pick < 95)
                send_item(OP_FLUSH, SYMBOL_W'($urandom()), $urandom(), LEN_W'($urandom()));
            else
                send_item(OP_UNUSED, SYMBOL_W'($urandom()), $urandom(), LEN_W'($urandom()));
        end
        items_if.valid <= 1'b0;

        // drain
        while (book.bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.mismatches == 0)
            $display("huffman_code_bit_packer: match");
        else
            $display("huffman_code_bit_packer: mismatch");
        $finish;
    end

    // output back-pressure in random bursts, none once calm
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                bytes_if.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_HOLD)) @(posedge clk);
            end
            bytes_if.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // byte monitor
    always @(posedge clk)
    begin
        if (rst_n && bytes_if.valid && bytes_if.ready)
            book.check_byte(bytes_if.out_byte, bytes_if.last_of_run);
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("huffman_code_bit_packer: mismatch");
        $finish;
    end

endmodule

[files.f]
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_in_if.sv
hw/rtl/hcbp_out_if.sv
hw/rtl/hcbp_front.sv
hw/rtl/hcbp_fifo.sv
hw/rtl/hcbp_back.sv
hw/rtl/huffman_code_bit_packer.sv
tb/huffman_code_bit_packer_test.sv
